// File: rtl/core/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// tmtw_pkg - shared types and constants of the text-mode terminal writer
// Holds the cell constants, character codes, register indexes and the
// microcode table that sequences the writer datapath.
// ----------------------------------------------------------------------------
package tmtw_pkg;

  // Default screen geometry
  localparam int DEF_NUM_COLUMNS = 80;
  localparam int DEF_NUM_ROWS    = 25;

  // Cell and beat field widths
  localparam int CELL_W = 16;
  localparam int CODE_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int COLOR_W = 4;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CODE_SPACE     = 8'h20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 1'b1;

  // Microcode steps
  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PUT,
    ST_RD,
    ST_RDW,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_OUT
  } step_t;

  typedef enum logic [1:0] {WR_NONE, WR_PUT, WR_BLANK, WR_COPY} wsel_t;
  typedef enum logic {RD_IDX, RD_COPY} rsel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_t;
  typedef enum logic [1:0] {DATA_HOLD, DATA_ZERO, DATA_MEM} dsel_t;
  typedef enum logic [2:0] {J_GO, J_DISPATCH, J_CNT, J_SCROLL, J_OUT} jump_t;
  typedef enum logic {LIM_ALL, LIM_COPY} lim_t;

  // One control word of the program
  typedef struct packed {
    logic    in_ready;
    wsel_t   wsel;
    rsel_t   rsel;
    cnt_op_t cnt;
    logic    cur_upd;
    dsel_t   dsel;
    logic    out_load;
    jump_t   jump;
    lim_t    lim;
    step_t   target;
    step_t   alt;
  } ctrl_t;

  // Program table: one control word per step
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '{in_ready: 1'b0, wsel: WR_NONE, rsel: RD_IDX, cnt: CNT_HOLD,
          cur_upd: 1'b0, dsel: DATA_HOLD, out_load: 1'b0, jump: J_GO,
          lim: LIM_ALL, target: ST_IDLE, alt: ST_IDLE};
    unique case (step)
      ST_CLR: begin
        c.wsel = WR_BLANK; c.cnt = CNT_INC; c.jump = J_CNT;
        c.lim = LIM_ALL; c.target = ST_IDLE; c.alt = ST_CLR;
      end
      ST_IDLE: begin
        c.in_ready = 1'b1; c.cnt = CNT_CLR; c.jump = J_DISPATCH;
      end
      ST_PUT: begin
        c.wsel = WR_PUT; c.cur_upd = 1'b1; c.dsel = DATA_ZERO;
        c.jump = J_SCROLL; c.target = ST_SCR_RD; c.alt = ST_OUT;
      end
      ST_RD: begin
        c.rsel = RD_IDX; c.target = ST_RDW;
      end
      ST_RDW: begin
        c.dsel = DATA_MEM; c.target = ST_OUT;
      end
      ST_SCR_RD: begin
        c.rsel = RD_COPY; c.target = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        c.wsel = WR_COPY; c.cnt = CNT_INC; c.jump = J_CNT;
        c.lim = LIM_COPY; c.target = ST_FILL; c.alt = ST_SCR_RD;
      end
      ST_FILL: begin
        c.wsel = WR_BLANK; c.cnt = CNT_INC; c.jump = J_CNT;
        c.lim = LIM_ALL; c.target = ST_OUT; c.alt = ST_FILL;
      end
      ST_OUT: begin
        c.out_load = 1'b1; c.jump = J_OUT; c.target = ST_IDLE;
      end
      default: c.target = ST_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/tmtw_screen_mem.sv
// ----------------------------------------------------------------------------
// tmtw_screen_mem - screen cell store
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmtw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/text_mode_terminal_writer.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer - text-mode console writer
// Screen store of character/attribute cells with a cursor, driven by a
// microcoded sequencer.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_ROWS*NUM_COLUMNS
// cells (2000 by default) that fills the store with 0x0F20 blanks; it takes no
// beat until that pass ends, while configuration writes are taken at once.
// A put beat then steps from acceptance to cell write and cursor update to
// result load, and a read beat from acceptance to read address, read wait
// and result load, the wait set by the single registered read port of the
// store. A put that moves past the last row scrolls: each of the
// (NUM_ROWS-1)*NUM_COLUMNS moved cells is read and then written, then the
// NUM_COLUMNS cells of the bottom row are blanked. The next input beat is
// taken while a finished result still waits in the output register.
module text_mode_terminal_writer #(
  parameter int NUM_COLUMNS = tmtw_pkg::DEF_NUM_COLUMNS,
  parameter int NUM_ROWS    = tmtw_pkg::DEF_NUM_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] mode, [8:1] char_code, [19:9] cell_index, [23:20] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: [10:0] cursor_pos, [26:11] cell_data, [31:27] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // configuration: index 0 fore_color, index 1 back_color
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tmtw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmtw_pkg::COLOR_W-1:0]      cfg_data
);

  import tmtw_pkg::*;

  localparam int CELL_COUNT = NUM_COLUMNS * NUM_ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int CW = $clog2(NUM_COLUMNS);
  localparam int RW = $clog2(NUM_ROWS);
  localparam int EXT_W = IDX_W + AW;

  // Sequencer state
  step_t step_r, step_nxt;
  ctrl_t ctrl;

  // Datapath registers
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CODE_W-1:0]  code_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CELL_W-1:0]  data_r;
  logic [COLOR_W-1:0] fore_r, back_r;
  logic               out_valid_r;
  logic [31:0]        out_tdata_r;

  // Store ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic in_acc, out_busy, cnt_last, scroll;
  logic is_nl, is_bs, is_pr, adv;
  logic [AW-1:0] line_start, bs_pos;
  logic [EXT_W-1:0] idx_ext;
  logic [AW+POS_W-1:0] pos_ext;
  logic idx_in_range;

  assign ctrl      = ucode(step_r);
  assign in_tready = ctrl.in_ready;
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid_r & ~out_tready;

  // Decode the held character
  assign is_nl = (code_r == CODE_NEWLINE);
  assign is_bs = (code_r == CODE_BACKSPACE);
  assign is_pr = ~code_r[7] & (code_r[6:5] != 2'b00);

  // Cursor arithmetic
  assign line_start = pos_r - AW'(col_r);
  assign bs_pos = ((col_r != '0) || (row_r != '0)) ? pos_r - AW'(1) : pos_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    adv     = 1'b0;
    if (is_nl) begin
      adv = 1'b1;
    end else if (is_bs) begin
      pos_nxt = bs_pos;
      if (col_r != '0) begin
        col_nxt = col_r - CW'(1);
      end else if (row_r != '0) begin
        row_nxt = row_r - RW'(1);
        col_nxt = CW'(NUM_COLUMNS - 1);
      end
    end else if (is_pr) begin
      if (col_r == CW'(NUM_COLUMNS - 1)) begin
        adv = 1'b1;
      end else begin
        col_nxt = col_r + CW'(1);
        pos_nxt = pos_r + AW'(1);
      end
    end
    scroll = adv & (row_r == RW'(NUM_ROWS - 1));
    // Advance to the next row start, staying on the last row on scroll
    if (adv) begin
      col_nxt = '0;
      if (scroll) begin
        pos_nxt = line_start;
      end else begin
        row_nxt = row_r + RW'(1);
        pos_nxt = line_start + AW'(NUM_COLUMNS);
      end
    end
  end

  // Counter end of sweep
  always_comb begin
    case (ctrl.lim)
      LIM_COPY: cnt_last = (cnt_r == AW'((NUM_ROWS - 1) * NUM_COLUMNS - 1));
      default:  cnt_last = (cnt_r == AW'(CELL_COUNT - 1));
    endcase
  end

  always_comb begin
    case (ctrl.cnt)
      CNT_CLR: cnt_nxt = '0;
      CNT_INC: cnt_nxt = cnt_r + AW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Store write and read selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = BLANK_CELL;
    case (ctrl.wsel)
      WR_PUT: begin
        mem_we    = is_bs | is_pr;
        mem_waddr = is_bs ? bs_pos : pos_r;
        mem_wdata = {back_r, fore_r, is_bs ? CODE_SPACE : code_r};
      end
      WR_BLANK: mem_we = 1'b1;
      WR_COPY: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign idx_ext      = {{AW{1'b0}}, idx_r};
  assign idx_in_range = (idx_ext < EXT_W'(CELL_COUNT));

  always_comb begin
    case (ctrl.rsel)
      RD_COPY: mem_raddr = cnt_r + AW'(NUM_COLUMNS);
      default: mem_raddr = idx_ext[AW-1:0];
    endcase
  end

  // Next step
  always_comb begin
    step_nxt = step_r;
    unique case (ctrl.jump)
      J_GO:       step_nxt = ctrl.target;
      J_DISPATCH: if (in_acc) begin
        step_nxt = in_tdata[0] ? ST_RD : ST_PUT;
      end
      J_CNT:      step_nxt = cnt_last ? ctrl.target : ctrl.alt;
      J_SCROLL:   step_nxt = scroll ? ctrl.target : ctrl.alt;
      J_OUT:      step_nxt = out_busy ? step_r : ctrl.target;
      default:    step_nxt = ST_IDLE;
    endcase
  end

  // Step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Counter and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (ctrl.cur_upd) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  // Capture the accepted beat and the result cell
  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= in_tdata[8:1];
      idx_r  <= in_tdata[19:9];
    end
    case (ctrl.dsel)
      DATA_ZERO: data_r <= '0;
      DATA_MEM:  data_r <= idx_in_range ? mem_rdata : '0;
      default:   data_r <= data_r;
    endcase
  end

  // Color registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= 4'hF;
      back_r <= 4'h0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORE_COLOR: fore_r <= cfg_data;
        REG_BACK_COLOR: back_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register
  assign pos_ext = {{POS_W{1'b0}}, pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && !out_busy) begin
      out_tdata_r <= {5'b0, data_r, pos_ext[POS_W-1:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  tmtw_screen_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: tb/tb_text_mode_terminal_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_mode_terminal_writer - self-checking bench of the text console writer
// Drives put and read beats with random gaps on both streams, keeps a shadow
// screen, cursor and color pair, and checks every result beat against the
// shadow in order. Covers control codes, wraps, backspace, scrolls, reads
// out of range and several color settings.
// ----------------------------------------------------------------------------
module tb_text_mode_terminal_writer;
  import tmtw_pkg::*;

  localparam int NUM_COLUMNS = DEF_NUM_COLUMNS;
  localparam int NUM_ROWS    = DEF_NUM_ROWS;
  localparam int CELLS       = NUM_COLUMNS * NUM_ROWS;
  localparam int QUIET_LIMIT = 20000;

  // One expected result beat
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_data;
  } echo_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data  = '0;

  // Shadow of the console state
  logic [CELL_W-1:0]  shadow_screen [0:CELLS-1];
  int                 shadow_col;
  int                 shadow_row;
  logic [COLOR_W-1:0] shadow_fore;
  logic [COLOR_W-1:0] shadow_back;

  echo_t echo_queue[$];
  echo_t fresh_echo;
  echo_t oldest_echo;
  int    mismatches;
  int    quiet_cycles = 0;
  int    out_hold;
  bit    in_steady;
  bit    out_steady;

  text_mode_terminal_writer #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_ROWS   (NUM_ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int cursor_now();
    return shadow_row * NUM_COLUMNS + shadow_col;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 100)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic reset_shadow();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = BLANK_CELL;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_fore = 4'hF;
    shadow_back = 4'h0;
  endtask

  // Apply one input beat to the shadow and form its expected result
  task automatic console_step(input logic m, input logic [CODE_W-1:0] code,
                              input logic [IDX_W-1:0] idx, output echo_t e);
    logic [CELL_W-1:0] attr;
    int pos;
    attr = {shadow_back, shadow_fore, 8'h00};
    e.cell_data = '0;
    if (m == 1'b0) begin
      if (code == CODE_NEWLINE) begin
        shadow_col = 0;
        shadow_row++;
      end else if (code == CODE_BACKSPACE) begin
        if (shadow_col > 0) begin
          shadow_col--;
        end else if (shadow_row > 0) begin
          shadow_row--;
          shadow_col = NUM_COLUMNS - 1;
        end
        pos = cursor_now();
        if (pos < CELLS) shadow_screen[pos] = attr | CELL_W'(CODE_SPACE);
      end else if (code >= CODE_SPACE && code <= 8'h7F) begin
        pos = cursor_now();
        if (pos < CELLS) shadow_screen[pos] = attr | CELL_W'(code);
        shadow_col++;
      end
      // wrap the column, then scroll past the last row
      if (shadow_col >= NUM_COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
      end
      if (shadow_row >= NUM_ROWS) begin
        for (int i = 0; i < (NUM_ROWS - 1) * NUM_COLUMNS; i++)
          shadow_screen[i] = shadow_screen[i + NUM_COLUMNS];
        for (int i = (NUM_ROWS - 1) * NUM_COLUMNS; i < CELLS; i++)
          shadow_screen[i] = BLANK_CELL;
        shadow_row = NUM_ROWS - 1;
      end
    end else if (idx < CELLS) begin
      e.cell_data = shadow_screen[idx];
    end
    e.pos = POS_W'(cursor_now());
  endtask

  // Monitor all three channels: predict on input, track colors, check output
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        console_step(in_tdata[0], in_tdata[8:1], in_tdata[19:9], fresh_echo);
        echo_queue.push_back(fresh_echo);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORE_COLOR: shadow_fore = cfg_data;
          REG_BACK_COLOR: shadow_back = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (echo_queue.size() == 0) begin
          report_mismatch("result beat with no pending item", out_tdata, 0);
        end else begin
          oldest_echo = echo_queue.pop_front();
          if (out_tdata[10:0] != oldest_echo.pos)
            report_mismatch("cursor_pos", out_tdata[10:0], oldest_echo.pos);
          if (out_tdata[26:11] != oldest_echo.cell_data)
            report_mismatch("cell_data", out_tdata[26:11], oldest_echo.cell_data);
        end
      end
    end
  end

  // Stall the result stream at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold   <= 0;
    end else if (out_hold != 0) begin
      out_tready <= 1'b0;
      out_hold   <= out_hold - 1;
    end else begin
      out_tready <= 1'b1;
      out_hold   <= pick_gap(out_steady);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Send one input beat; valid stays high so the next beat can follow at once
  task automatic send_item(input logic m, input logic [CODE_W-1:0] code,
                           input logic [IDX_W-1:0] idx);
    int g;
    g = pick_gap(in_steady);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata  <= {4'b0000, idx, code, m};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic type_char(input logic [CODE_W-1:0] code);
    send_item(1'b0, code, IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic peek_cell(input logic [IDX_W-1:0] idx);
    send_item(1'b1, CODE_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic type_printable();
    type_char(CODE_W'($urandom_range(8'h20, 8'h7F)));
  endtask

  // Hold input, wait for every pending result, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (echo_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Weighted mix of well-formed text, reads and noise
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 52)      type_printable();
    else if (r < 60) type_char(CODE_NEWLINE);
    else if (r < 67) type_char(CODE_BACKSPACE);
    else if (r < 77) peek_cell(IDX_W'(cursor_now() + $urandom_range(0, 8) - 4));
    else if (r < 87) peek_cell(IDX_W'($urandom_range(0, 2047)));
    else if (r < 93) type_char(CODE_W'($urandom_range(8'h00, 8'h1F)));
    else             type_char(CODE_W'($urandom_range(8'h80, 8'hFF)));
  endtask

  task automatic test_directed_codes();
    type_char(CODE_BACKSPACE);      // backspace at the top-left cell stays put
    peek_cell(IDX_W'(0));
    type_char(8'h41);
    type_char(CODE_SPACE);
    type_char(8'h7F);
    // other codes write nothing
    type_char(8'h00);
    type_char(8'h1F);
    type_char(8'h09);
    type_char(8'h0D);
    type_char(8'h80);
    type_char(8'hFF);
    type_char(CODE_NEWLINE);
    type_char(CODE_BACKSPACE);      // wraps back to the end of row 0
    type_char(8'h7E);               // last column: overflow to the next row
    peek_cell(IDX_W'(NUM_COLUMNS - 1));
    peek_cell(IDX_W'(1));
    peek_cell(IDX_W'(2));
    send_item(1'b1, 8'hFF, IDX_W'(CELLS - 1));
    peek_cell(IDX_W'(CELLS));       // out of range reads return zero
    peek_cell(11'h7FF);
    send_item(1'b1, CODE_NEWLINE, 11'h555);
    send_item(1'b1, CODE_BACKSPACE, 11'h2AA);
    settle();
  endtask

  task automatic test_color_settings();
    logic [COLOR_W-1:0] fores [4];
    logic [COLOR_W-1:0] backs [4];
    fores = '{4'h0, 4'hF, 4'h0, 4'h9};
    backs = '{4'hF, 4'hF, 4'h0, 4'h6};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_FORE_COLOR, fores[s]);
      write_reg(REG_BACK_COLOR, backs[s]);
      repeat (12) random_item();
      type_printable();
      type_char(CODE_BACKSPACE);
      peek_cell(IDX_W'(cursor_now()));
      settle();
    end
  endtask

  task automatic test_scroll_paths();
    int rows_left;
    write_reg(REG_FORE_COLOR, 4'h3);
    write_reg(REG_BACK_COLOR, 4'hC);
    // walk down to the last row with short lines
    rows_left = NUM_ROWS - 1 - shadow_row;
    repeat (rows_left) begin
      repeat ($urandom_range(0, 5)) type_printable();
      type_char(CODE_NEWLINE);
    end
    settle();
    // a full bottom row wraps and scrolls, a newline scrolls again
    if (shadow_col != 0) type_char(CODE_NEWLINE);
    repeat (NUM_COLUMNS) type_printable();
    repeat (10) type_printable();
    type_char(CODE_NEWLINE);
    type_char(CODE_BACKSPACE);      // back up into the row above
    repeat (6) peek_cell(IDX_W'((NUM_ROWS - 1) * NUM_COLUMNS + $urandom_range(0, NUM_COLUMNS - 1)));
    repeat (6) peek_cell(IDX_W'((NUM_ROWS - 2) * NUM_COLUMNS + $urandom_range(0, NUM_COLUMNS - 1)));
    peek_cell(IDX_W'(CELLS - 1));
    settle();
    // back-to-back text with no stalls on either side
    in_steady  = 1'b1;
    out_steady = 1'b1;
    repeat (40) type_printable();
    type_char(CODE_NEWLINE);
    in_steady  = 1'b0;
    out_steady = 1'b0;
    repeat (30) type_char(CODE_BACKSPACE);
    repeat (4) peek_cell(IDX_W'(cursor_now() + $urandom_range(0, 40)));
    settle();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_FORE_COLOR, COLOR_W'($urandom_range(0, 15)));
      write_reg(REG_BACK_COLOR, COLOR_W'($urandom_range(0, 15)));
      in_steady  = (ph == 2);
      out_steady = (ph == 3);
      repeat (60) random_item();
      settle();
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  initial begin
    mismatches   = 0;
    in_steady    = 1'b0;
    out_steady   = 1'b0;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_FORE_COLOR, 4'hF);
    write_reg(REG_BACK_COLOR, 4'h0);
    test_directed_codes();
    test_color_settings();
    test_scroll_paths();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    if (echo_queue.size() != 0)
      report_mismatch("results never returned", echo_queue.size(), 0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
